// File: hw/rtl/dbf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbf_pkg: shared types and constants of the duplicate-rejecting byte queue
// Queue depth, request and status codes, and the control word of one cell.
// ----------------------------------------------------------------------------
package dbf_pkg;

	// number of queue slots, one cell each (2 to 256)
	localparam int DEPTH = 256;
	// width of the entry count, which must hold DEPTH itself
	localparam int CNT_W = $clog2(DEPTH + 1);

	// request codes
	localparam logic [1:0] REQ_ENQ  = 2'd0;
	localparam logic [1:0] REQ_DEQ  = 2'd1;
	localparam logic [1:0] REQ_TAIL = 2'd2;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_DUP   = 2'd1,
		ST_EMPTY = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	// control broadcast to every cell
	typedef struct packed {
		logic shift;	// dequeue: take the neighbour's contents
		logic load;	// enqueue: first free cell captures the byte
	} cell_ctrl_t;

endpackage

// File: hw/rtl/dedup_byte_fifo_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dedup_byte_fifo_top: byte queue that refuses duplicate values
// First-in first-out queue of bytes built as a chain of cells, with a
// presence map that rejects a byte already queued.
// ----------------------------------------------------------------------------
// Use:
//   Issue a request by raising start with req_type and value. The item is
//   taken at a rising edge where start is high and busy is low; busy stays
//   low, so one item can be taken every cycle.
//   req_type: enqueue value, dequeue oldest, or read newest value.
//   Exactly one result per item appears in the cycle after the item is taken:
//   done is high for that single cycle with status, data, empty_res and
//   count. Throughput is one item per cycle; the presence map lookup and
//   the cell load decision for an item settle in the cycle in which that
//   item is taken.
//   The receiver cannot hold results off: sample them whenever done is high.
//   A duplicate enqueue is rejected before the full check; dequeue or read
//   of an empty queue reports empty; an unused request code is a no-op.
//   Reset (arst_n low) empties the queue and clears the presence map at
//   once; no clearing pass is needed.
// Structure:
//   Cell 0 holds the oldest byte. A dequeue shifts every cell towards the
//   head by one; an enqueue lands in the first free cell. The newest byte
//   is kept in a separate register for the read request.
// ----------------------------------------------------------------------------
module dedup_byte_fifo_top (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [1:0]                req_type,
	input  logic [7:0]                value,
	output logic                      done,
	output logic [1:0]                status,
	output logic [7:0]                data,
	output logic                      empty_res,
	output logic [dbf_pkg::CNT_W-1:0] count
);

	logic                      accept;
	logic                      is_enq;
	logic                      is_deq;
	logic                      is_tail;
	logic                      dup;
	logic                      full;
	logic                      empty;
	logic                      enq_ok;
	logic                      deq_ok;
	dbf_pkg::cell_ctrl_t       ctrl;
	dbf_pkg::status_t          status_d;
	logic [7:0]                data_d;

	logic                      cell_valid [dbf_pkg::DEPTH];
	logic [7:0]                cell_data  [dbf_pkg::DEPTH];

	logic [dbf_pkg::CNT_W-1:0] count_q;
	logic [7:0]                newest_q;
	logic                      done_q;
	dbf_pkg::status_t          status_q;
	logic [7:0]                data_q;

	// every request is taken at once: never hold off the sender
	assign busy   = 1'b0;
	assign accept = start && !busy;

	assign is_enq  = accept && (req_type == dbf_pkg::REQ_ENQ);
	assign is_deq  = accept && (req_type == dbf_pkg::REQ_DEQ);
	assign is_tail = accept && (req_type == dbf_pkg::REQ_TAIL);

	assign full  = (count_q == dbf_pkg::CNT_W'(dbf_pkg::DEPTH));
	assign empty = (count_q == '0);

	assign enq_ok = is_enq && !dup && !full;
	assign deq_ok = is_deq && !empty;

	assign ctrl.shift = deq_ok;
	assign ctrl.load  = enq_ok;

	dbf_presence u_presence (
		.clk      (clk),
		.arst_n   (arst_n),
		.set_en   (enq_ok),
		.set_idx  (value),
		.clr_en   (deq_ok),
		.clr_idx  (cell_data[0]),
		.look_idx (value),
		.hit      (dup)
	);

	// chain of cells: each one takes its neighbour's byte on a dequeue
	for (genvar g = 0; g < dbf_pkg::DEPTH; g++) begin : g_cell
		logic       prev_v;
		logic       next_v;
		logic [7:0] next_d;

		if (g == 0) begin : g_head
			assign prev_v = 1'b1;
		end else begin : g_body
			assign prev_v = cell_valid[g-1];
		end

		if (g == dbf_pkg::DEPTH - 1) begin : g_last
			assign next_v = 1'b0;
			assign next_d = '0;
		end else begin : g_link
			assign next_v = cell_valid[g+1];
			assign next_d = cell_data[g+1];
		end

		dbf_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.value      (value),
			.prev_valid (prev_v),
			.next_valid (next_v),
			.next_data  (next_d),
			.valid      (cell_valid[g]),
			.data       (cell_data[g])
		);
	end

	// result of the current item
	always_comb begin
		status_d = dbf_pkg::ST_OK;
		data_d   = '0;
		if (is_enq) begin
			if (dup) begin
				status_d = dbf_pkg::ST_DUP;
			end else if (full) begin
				status_d = dbf_pkg::ST_FULL;
			end
		end else if (is_deq) begin
			if (empty) begin
				status_d = dbf_pkg::ST_EMPTY;
			end else begin
				data_d = cell_data[0];
			end
		end else if (is_tail) begin
			if (empty) begin
				status_d = dbf_pkg::ST_EMPTY;
			end else begin
				data_d = newest_q;
			end
		end
	end

	// advance the entry count, hold the newest byte, raise done for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			if (enq_ok) begin
				count_q <= dbf_pkg::CNT_W'(count_q + 1'b1);
			end else if (deq_ok) begin
				count_q <= dbf_pkg::CNT_W'(count_q - 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (enq_ok) begin
			newest_q <= value;
		end
		if (accept) begin
			status_q <= status_d;
			data_q   <= data_d;
		end
	end

	// the count register already holds the state after the item
	assign done      = done_q;
	assign status    = status_q;
	assign data      = data_q;
	assign count     = count_q;
	assign empty_res = (count_q == '0);

	// head cell is filled exactly when the queue is not empty
	a_head_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) == !cell_valid[0])
		else $error("head cell valid disagrees with entry count");

	// last cell is filled exactly when the queue is full
	a_last_valid: assert property (@(posedge clk) disable iff (!arst_n)
		full == cell_valid[dbf_pkg::DEPTH-1])
		else $error("last cell valid disagrees with full count");

	// a dequeue from a non-empty queue drops the count by one
	a_deq_count: assert property (@(posedge clk) disable iff (!arst_n)
		deq_ok |=> (count_q == dbf_pkg::CNT_W'($past(count_q) - 1'b1)))
		else $error("entry count not reduced after dequeue");

	// every taken item yields its result on the next cycle
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("no result for an accepted item");

endmodule

// File: hw/rtl/dbf_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbf_cell: one slot of the queue chain
// Holds one byte and its valid bit; shifts towards the head on dequeue and
// captures the new byte when it is the first free slot on enqueue.
// ----------------------------------------------------------------------------
module dbf_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  dbf_pkg::cell_ctrl_t ctrl,
	input  logic [7:0]          value,
	input  logic                prev_valid,
	input  logic                next_valid,
	input  logic [7:0]          next_data,
	output logic                valid,
	output logic [7:0]          data
);

	logic       valid_q;
	logic [7:0] data_q;
	logic       take;

	// first free slot: the one behind is filled, this one is not
	assign take = ctrl.load && prev_valid && !valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= next_valid;
		end else if (take) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			data_q <= next_data;
		end else if (take) begin
			data_q <= value;
		end
	end

	assign valid = valid_q;
	assign data  = data_q;

endmodule

// File: hw/rtl/dbf_presence.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbf_presence: map of byte values currently queued
// One flag per byte value; set on enqueue, cleared on dequeue.
// ----------------------------------------------------------------------------
module dbf_presence (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       set_en,
	input  logic [7:0] set_idx,
	input  logic       clr_en,
	input  logic [7:0] clr_idx,
	input  logic [7:0] look_idx,
	output logic       hit
);

	logic [255:0] flags_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else begin
			if (set_en) begin
				flags_q[set_idx] <= 1'b1;
			end
			if (clr_en) begin
				flags_q[clr_idx] <= 1'b0;
			end
		end
	end

	assign hit = flags_q[look_idx];

	// enqueue and dequeue never share a request
	a_no_set_clr: assert property (@(posedge clk) disable iff (!arst_n)
		!(set_en && clr_en))
		else $error("presence map set and clear in one cycle");

	// a set flag is seen on the next cycle
	a_set_seen: assert property (@(posedge clk) disable iff (!arst_n)
		set_en |=> flags_q[$past(set_idx)])
		else $error("presence flag not set after enqueue");

endmodule
